[hw/rtl/i2cbb_pkg.sv]
// ---------------------------------------------------------------------------
// i2cbb_pkg: shared types and constants for the I2C bit-bang master
// Command codes, item layouts and the controller state record.
// ---------------------------------------------------------------------------
package i2cbb_pkg;

    // Field and state widths
    localparam int OP_W    = 3;
    localparam int BYTE_W  = 8;
    localparam int TICK_W  = 10;
    localparam int POLL_W  = 8;
    localparam int PHASE_W = 4;
    localparam int BITC_W  = 4;
    localparam int DELAY_W = 14;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_US   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_POLL_LIMIT = 1'd1;

    // Configuration reset values
    localparam logic [TICK_W-1:0] TICKS_PER_US_RESET   = 10'd8;
    localparam logic [POLL_W-1:0] ACK_POLL_LIMIT_RESET = 8'd250;

    // Phase in which wait-ack polls SDA
    localparam logic [PHASE_W-1:0] POLL_PHASE = 4'd2;

    // Bits per byte on the bus
    localparam logic [BITC_W-1:0] BITS_PER_BYTE = 4'd8;

    // Bus commands
    typedef enum logic [OP_W-1:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4,
        CMD_WAIT  = 3'd5
    } i2cbb_cmd_t;

    // Input item: one bus tick
    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [BYTE_W-1:0] write_data;
        logic              send_ack;
        logic              sda_sampled;
    } i2cbb_in_t;

    // Result item: line drives and status after the tick
    typedef struct packed {
        logic              scl_level;
        logic              sda_level;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] read_byte;
        logic              ack_failed;
    } i2cbb_out_t;

    // Controller state
    typedef struct packed {
        i2cbb_cmd_t         cmd;
        logic [PHASE_W-1:0] phase;
        logic [DELAY_W-1:0] delay;
        logic [BITC_W-1:0]  bit_cnt;
        logic [BYTE_W-1:0]  shift;
        logic [POLL_W-1:0]  poll;
        logic               ack_choice;
        logic               scl_drive;
        logic               sda_drive;
        logic               ack_fail;
    } i2cbb_state_t;

    localparam i2cbb_state_t STATE_RESET = '{
        cmd:        CMD_NONE,
        phase:      '0,
        delay:      '0,
        bit_cnt:    '0,
        shift:      '0,
        poll:       '0,
        ack_choice: 1'b0,
        scl_drive:  1'b1,
        sda_drive:  1'b1,
        ack_fail:   1'b0
    };

    // Step outcome: new state plus completion info
    typedef struct packed {
        i2cbb_state_t st;
        logic         done;
        i2cbb_cmd_t   done_cmd;
    } i2cbb_step_t;

endpackage

[hw/rtl/i2cbb_step.sv]
// ---------------------------------------------------------------------------
// i2cbb_step: one-tick next-state logic of the I2C master
// Given the current state and one input item, computes the next state and
// the result item. Purely combinational.
// ---------------------------------------------------------------------------
module i2cbb_step (
    input  i2cbb_pkg::i2cbb_state_t           cur,
    input  i2cbb_pkg::i2cbb_in_t              item,
    input  logic [i2cbb_pkg::TICK_W-1:0]      ticks_per_us,
    input  logic [i2cbb_pkg::POLL_W-1:0]      ack_poll_limit,
    output i2cbb_pkg::i2cbb_state_t           nxt,
    output i2cbb_pkg::i2cbb_out_t             res
);

    logic [i2cbb_pkg::TICK_W-1:0]  tick_eff;
    logic [i2cbb_pkg::DELAY_W-1:0] tick_ext;
    logic [i2cbb_pkg::DELAY_W-1:0] dly5;
    logic [i2cbb_pkg::DELAY_W-1:0] dly6;
    logic [i2cbb_pkg::DELAY_W-1:0] dly10;
    i2cbb_pkg::i2cbb_step_t        r;

    // Phase delays: 5, 6 and 10 us by shift and add; zero counts as one
    assign tick_eff = (ticks_per_us == '0) ? i2cbb_pkg::TICK_W'(1) : ticks_per_us;
    assign tick_ext = i2cbb_pkg::DELAY_W'(tick_eff);
    assign dly5     = (tick_ext << 2) + tick_ext;
    assign dly6     = (tick_ext << 2) + (tick_ext << 1);
    assign dly10    = dly5 << 1;

    // Close out the running command
    function automatic i2cbb_pkg::i2cbb_step_t finish(i2cbb_pkg::i2cbb_step_t a);
        i2cbb_pkg::i2cbb_step_t b;
        b             = a;
        b.done        = 1'b1;
        b.done_cmd    = a.st.cmd;
        b.st.cmd      = i2cbb_pkg::CMD_NONE;
        b.st.phase    = '0;
        b.st.delay    = '0;
        return b;
    endfunction

    // Line actions on entry to a phase, and its delay
    function automatic i2cbb_pkg::i2cbb_step_t enter(
        i2cbb_pkg::i2cbb_step_t        a,
        logic                          sda_in,
        logic [i2cbb_pkg::DELAY_W-1:0] d5,
        logic [i2cbb_pkg::DELAY_W-1:0] d6,
        logic [i2cbb_pkg::DELAY_W-1:0] d10
    );
        i2cbb_pkg::i2cbb_step_t b;
        b = a;
        unique case (a.st.cmd)
            i2cbb_pkg::CMD_START:
            begin
                if (a.st.phase == 4'd0)
                begin
                    b.st.scl_drive = 1'b1;
                    b.st.sda_drive = 1'b1;
                    b.st.delay     = d10;
                end
                else if (a.st.phase == 4'd1)
                begin
                    b.st.sda_drive = 1'b0;
                    b.st.delay     = d10;
                end
                else
                begin
                    b.st.scl_drive = 1'b0;
                    b = finish(b);
                end
            end
            i2cbb_pkg::CMD_STOP:
            begin
                if (a.st.phase == 4'd0)
                begin
                    b.st.scl_drive = 1'b0;
                    b.st.sda_drive = 1'b0;
                    b.st.delay     = d10;
                end
                else if (a.st.phase == 4'd1)
                begin
                    b.st.scl_drive = 1'b1;
                    b.st.sda_drive = 1'b1;
                    b.st.delay     = d10;
                end
                else
                begin
                    b = finish(b);
                end
            end
            i2cbb_pkg::CMD_WRITE:
            begin
                if (a.st.phase == 4'd0)
                begin
                    b.st.scl_drive = 1'b0;
                    b.st.sda_drive = a.st.shift[i2cbb_pkg::BYTE_W-1];
                    b.st.shift     = {a.st.shift[i2cbb_pkg::BYTE_W-2:0], 1'b0};
                    b.st.delay     = d5;
                end
                else if (a.st.phase == 4'd1)
                begin
                    b.st.scl_drive = 1'b1;
                    b.st.delay     = d5;
                end
                else if (a.st.phase == 4'd2)
                begin
                    b.st.scl_drive = 1'b0;
                    b.st.delay     = d6;
                end
                else
                begin
                    b = finish(b);
                end
            end
            i2cbb_pkg::CMD_READ:
            begin
                if (a.st.phase == 4'd0)
                begin
                    b.st.scl_drive = 1'b0;
                    b.st.sda_drive = 1'b1;
                    b.st.delay     = d5;
                end
                else if (a.st.phase == 4'd1)
                begin
                    // sample the data bit as SCL is released
                    b.st.scl_drive = 1'b1;
                    b.st.shift     = {a.st.shift[i2cbb_pkg::BYTE_W-2:0], sda_in};
                    b.st.delay     = d5;
                end
                else if (a.st.phase == 4'd3)
                begin
                    b.st.scl_drive = 1'b0;
                    b.st.sda_drive = ~a.st.ack_choice;
                    b.st.delay     = d5;
                end
                else if (a.st.phase == 4'd4)
                begin
                    b.st.scl_drive = 1'b1;
                    b.st.delay     = d6;
                end
                else
                begin
                    b.st.scl_drive = 1'b0;
                    b = finish(b);
                end
            end
            i2cbb_pkg::CMD_WAIT:
            begin
                if (a.st.phase == 4'd0)
                begin
                    b.st.sda_drive = 1'b1;
                    b.st.delay     = d5;
                end
                else if (a.st.phase == 4'd1)
                begin
                    b.st.scl_drive = 1'b1;
                    b.st.delay     = d6;
                end
                else if (a.st.phase == i2cbb_pkg::POLL_PHASE)
                begin
                    b.st.delay = '0;
                end
                else if (a.st.phase == 4'd3)
                begin
                    // timeout: stop sequence
                    b.st.scl_drive = 1'b0;
                    b.st.sda_drive = 1'b0;
                    b.st.delay     = d10;
                end
                else if (a.st.phase == 4'd4)
                begin
                    b.st.scl_drive = 1'b1;
                    b.st.sda_drive = 1'b1;
                    b.st.delay     = d10;
                end
                else
                begin
                    b = finish(b);
                end
            end
            default:
            begin
                b = finish(b);
            end
        endcase
        return b;
    endfunction

    // Next-state for one tick
    always_comb
    begin
        r.st       = cur;
        r.done     = 1'b0;
        r.done_cmd = i2cbb_pkg::CMD_NONE;

        if (cur.cmd == i2cbb_pkg::CMD_NONE)
        begin
            // idle: take a valid command
            if (item.operation >= i2cbb_pkg::OP_W'(i2cbb_pkg::CMD_START) &&
                item.operation <= i2cbb_pkg::OP_W'(i2cbb_pkg::CMD_WAIT))
            begin
                r.st.cmd      = i2cbb_pkg::i2cbb_cmd_t'(item.operation);
                r.st.phase    = '0;
                r.st.bit_cnt  = '0;
                r.st.poll     = '0;
                r.st.ack_fail = 1'b0;
                if (item.operation == i2cbb_pkg::OP_W'(i2cbb_pkg::CMD_WRITE))
                begin
                    r.st.shift = item.write_data;
                end
                else if (item.operation == i2cbb_pkg::OP_W'(i2cbb_pkg::CMD_READ))
                begin
                    r.st.shift      = '0;
                    r.st.ack_choice = item.send_ack;
                end
                r = enter(r, item.sda_sampled, dly5, dly6, dly10);
            end
        end
        else if (cur.cmd == i2cbb_pkg::CMD_WAIT && cur.phase == i2cbb_pkg::POLL_PHASE)
        begin
            // ack poll with SCL high
            if (!item.sda_sampled)
            begin
                r.st.scl_drive = 1'b0;
                r = finish(r);
            end
            else if (cur.poll >= ack_poll_limit)
            begin
                r.st.ack_fail = 1'b1;
                r.st.phase    = 4'd3;
                r = enter(r, item.sda_sampled, dly5, dly6, dly10);
            end
            else
            begin
                r.st.poll = cur.poll + 1'b1;
            end
        end
        else
        begin
            // count down the phase delay, then move on
            if (cur.delay != '0)
            begin
                r.st.delay = cur.delay - 1'b1;
            end
            if (r.st.delay == '0)
            begin
                if ((cur.cmd == i2cbb_pkg::CMD_WRITE && cur.phase == 4'd2) ||
                    (cur.cmd == i2cbb_pkg::CMD_READ && cur.phase == 4'd1))
                begin
                    r.st.bit_cnt = cur.bit_cnt + 1'b1;
                    r.st.phase   = (r.st.bit_cnt < i2cbb_pkg::BITS_PER_BYTE) ? 4'd0 : 4'd3;
                end
                else
                begin
                    r.st.phase = cur.phase + 1'b1;
                end
                r = enter(r, item.sda_sampled, dly5, dly6, dly10);
            end
        end
    end

    // Result item from the new state
    always_comb
    begin
        nxt           = r.st;
        res.scl_level = r.st.scl_drive;
        res.sda_level = r.st.sda_drive;
        res.busy_res  = (r.st.cmd != i2cbb_pkg::CMD_NONE);
        res.done_res  = r.done;
        res.read_byte = (r.done && r.done_cmd == i2cbb_pkg::CMD_READ) ? r.st.shift : '0;
        res.ack_failed = r.done && (r.done_cmd == i2cbb_pkg::CMD_WAIT) && r.st.ack_fail;
    end

endmodule

[hw/rtl/i2c_bitbang_master_unit.sv]
// An accepted tick's result goes to the output register, or to the skid entry if that is held.
// Throughput: one tick item per cycle while cmd_stall is low; the step logic is a single pass over the state register.
// A two-entry output buffer lets a new tick in while one result waits to be taken.
// Reset: bus lines released, controller idle, ticks_per_us = 8, ack_poll_limit = 250.
// ---------------------------------------------------------------------------
// i2c_bitbang_master_unit: I2C master driving open-drain SCL and SDA
// Start, stop, write byte, read byte and wait-ack sequences, timed in ticks.
// ---------------------------------------------------------------------------
module i2c_bitbang_master_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // tick items
    input  logic                                 cmd_valid,
    output logic                                 cmd_stall,
    input  i2cbb_pkg::i2cbb_in_t                 cmd_item,
    // result items
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output i2cbb_pkg::i2cbb_out_t                res_item,
    // configuration writes
    input  logic                                 cfg_we,
    input  logic [i2cbb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [i2cbb_pkg::TICK_W-1:0]         cfg_data
);

    logic [i2cbb_pkg::TICK_W-1:0] ticks_per_us_reg;
    logic [i2cbb_pkg::POLL_W-1:0] ack_poll_limit_reg;
    i2cbb_pkg::i2cbb_state_t      state_reg;
    i2cbb_pkg::i2cbb_state_t      state_next;
    i2cbb_pkg::i2cbb_out_t        step_res;
    logic                         out_valid_reg;
    i2cbb_pkg::i2cbb_out_t        out_data_reg;
    logic                         skid_valid_reg;
    i2cbb_pkg::i2cbb_out_t        skid_data_reg;
    logic                         accept;
    logic                         pop;

    assign accept    = cmd_valid && !cmd_stall;
    assign pop       = out_valid_reg && !res_stall;
    assign cmd_stall = skid_valid_reg;
    assign res_valid = out_valid_reg;
    assign res_item  = out_data_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_per_us_reg   <= i2cbb_pkg::TICKS_PER_US_RESET;
            ack_poll_limit_reg <= i2cbb_pkg::ACK_POLL_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                i2cbb_pkg::CFG_TICKS_PER_US:   ticks_per_us_reg <= cfg_data;
                i2cbb_pkg::CFG_ACK_POLL_LIMIT: ack_poll_limit_reg <= cfg_data[i2cbb_pkg::POLL_W-1:0];
                default:                       ;
            endcase
        end
    end

    // Tick logic
    i2cbb_step u_step (
        .cur            (state_reg),
        .item           (cmd_item),
        .ticks_per_us   (ticks_per_us_reg),
        .ack_poll_limit (ack_poll_limit_reg),
        .nxt            (state_next),
        .res            (step_res)
    );

    // Controller state advances once per accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= i2cbb_pkg::STATE_RESET;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // Output register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payloads
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_data_reg <= step_res;
            end
            else
            begin
                out_data_reg <= step_res;
            end
        end
    end

endmodule
